// ===== hw/rtl/mandelbrot_escape_time_macros.svh =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time assertion macros
// Shared property shorthands for the escape-time block.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define MBE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define MBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Fixed widths and constants shared by the escape-time modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

    // Input point format: signed Q4.28 per component
    localparam int IN_W     = 32;
    localparam int IN_FRAC  = 28;
    // Internal values carry six integer bits (sign included)
    localparam int INT_BITS = 6;

    // Multiplier digit handled by one cell of the chain
    localparam int DIGIT_W  = 16;

    // Budget register and result count
    localparam int CFG_W    = 16;
    localparam int REM_W    = 16;
    localparam logic [CFG_W-1:0] MAX_ITER_RESET = 16'd30;

    // Escape when |z|^2 exceeds this (integer units)
    localparam int ESC_BOUND_SQ = 4;

endpackage

`default_nettype wire

// ===== hw/rtl/mbe_cell.sv =====
// ----------------------------------------------------------------------------
// Escape-time multiplier cell
// One digit slice of the squaring chain: adds the partial products of one
// multiplier digit to the running re*re, im*im and re*im sums.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_cell #(
    parameter  int MAG_W = 34,
    parameter  int IDX   = 0,
    localparam int ACC_W = 2 * MAG_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             v_in,
    input  wire logic [MAG_W-1:0] ax,
    input  wire logic [MAG_W-1:0] ay,
    input  wire logic [ACC_W-1:0] p_in,
    input  wire logic [ACC_W-1:0] q_in,
    input  wire logic [ACC_W-1:0] r_in,
    output logic                  v_out,
    output logic      [ACC_W-1:0] p_out,
    output logic      [ACC_W-1:0] q_out,
    output logic      [ACC_W-1:0] r_out
);
    import mbe_pkg::*;

    localparam int SH    = IDX * DIGIT_W;
    localparam int PAD_W = (SH + DIGIT_W > MAG_W) ? SH + DIGIT_W : MAG_W;
    localparam int PP_W  = MAG_W + DIGIT_W;

    logic [PAD_W-1:0]   ax_pad, ay_pad;
    logic [DIGIT_W-1:0] ax_dig, ay_dig;
    logic [PP_W-1:0]    pp_p, pp_q, pp_r;
    logic               v_reg;
    logic [ACC_W-1:0]   p_reg, q_reg, r_reg;
    logic [ACC_W-1:0]   p_next, q_next, r_next;

    assign ax_pad = PAD_W'(ax);
    assign ay_pad = PAD_W'(ay);
    assign ax_dig = ax_pad[SH +: DIGIT_W];
    assign ay_dig = ay_pad[SH +: DIGIT_W];

    assign pp_p = PP_W'(ax) * PP_W'(ax_dig);
    assign pp_q = PP_W'(ay) * PP_W'(ay_dig);
    assign pp_r = PP_W'(ax) * PP_W'(ay_dig);

    // Align this digit's partial products and fold them into the sums
    assign p_next = p_in + (ACC_W'(pp_p) << SH);
    assign q_next = q_in + (ACC_W'(pp_q) << SH);
    assign r_next = r_in + (ACC_W'(pp_r) << SH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_in;
        end
        p_reg <= p_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign v_out = v_reg;
    assign p_out = p_reg;
    assign q_out = q_reg;
    assign r_out = r_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mbe_step.sv =====
// ----------------------------------------------------------------------------
// Escape-time step update
// Rounds and saturates the chain's exact products, forms the next z and
// tests the exact squared magnitude against the escape radius.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_step #(
    parameter  int FRAC_BITS = 28,
    localparam int MAG_W     = FRAC_BITS + mbe_pkg::INT_BITS,
    localparam int ACC_W     = 2 * MAG_W
) (
    input  wire logic                    [ACC_W-1:0] p,
    input  wire logic                    [ACC_W-1:0] q,
    input  wire logic                    [ACC_W-1:0] r,
    input  wire logic                                r_neg,
    input  wire logic signed             [MAG_W-1:0] c_re,
    input  wire logic signed             [MAG_W-1:0] c_im,
    output logic signed                  [MAG_W-1:0] re_new,
    output logic signed                  [MAG_W-1:0] im_new,
    output logic                                     beyond
);
    import mbe_pkg::*;

    localparam int SHW = ACC_W - FRAC_BITS;       // width of p >> FRAC_BITS
    localparam int RSW = ACC_W - FRAC_BITS + 1;   // width of r >> (FRAC_BITS-1)
    localparam logic signed [MAG_W-1:0] FIX_MAX = {1'b0, {(MAG_W-1){1'b1}}};
    localparam logic signed [MAG_W-1:0] FIX_MIN = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [ACC_W:0] ESC_LIMIT =
        (ACC_W+1)'(ESC_BOUND_SQ) << (2 * FRAC_BITS);

    logic [SHW-1:0]            p_sh, q_sh;
    logic                      p_ovf, q_ovf;
    logic signed [MAG_W-1:0]   p_sat, q_sat;
    logic [RSW-1:0]            r_sh;
    logic                      r_frac_nz;
    logic [RSW:0]              r_mag;
    logic [MAG_W-1:0]          r_low;
    logic                      r_pos_ovf, r_neg_ovf;
    logic signed [MAG_W-1:0]   r_sat;
    logic signed [MAG_W+1:0]   sum_re;
    logic signed [MAG_W:0]     sum_im;
    logic [2:0]                re_top;
    logic [1:0]                im_top;
    logic [ACC_W:0]            mag_sq;

    // Squares are non-negative: floor is a plain shift, then clip at the top
    assign p_sh  = p[ACC_W-1:FRAC_BITS];
    assign q_sh  = q[ACC_W-1:FRAC_BITS];
    assign p_ovf = |p_sh[SHW-1:MAG_W-1];
    assign q_ovf = |q_sh[SHW-1:MAG_W-1];
    assign p_sat = p_ovf ? FIX_MAX : $signed(p_sh[MAG_W-1:0]);
    assign q_sat = q_ovf ? FIX_MAX : $signed(q_sh[MAG_W-1:0]);

    // 2*re*im from a magnitude product: a negative result rounds its magnitude up
    assign r_sh      = r[ACC_W-1:FRAC_BITS-1];
    assign r_frac_nz = |r[FRAC_BITS-2:0];
    assign r_mag     = {1'b0, r_sh} + (RSW+1)'(r_neg && r_frac_nz);
    assign r_low     = r_mag[MAG_W-1:0];
    assign r_pos_ovf = |r_mag[RSW:MAG_W-1];
    assign r_neg_ovf = (|r_mag[RSW:MAG_W]) || (r_mag[MAG_W-1] && (|r_mag[MAG_W-2:0]));

    always_comb begin
        if (r_neg) begin
            r_sat = r_neg_ovf ? FIX_MIN : $signed(-r_low);
        end else begin
            r_sat = r_pos_ovf ? FIX_MAX : $signed(r_low);
        end
    end

    assign sum_re = (MAG_W+2)'(p_sat) - (MAG_W+2)'(q_sat) + (MAG_W+2)'(c_re);
    assign sum_im = (MAG_W+1)'(r_sat) + (MAG_W+1)'(c_im);

    // Saturate: the sum fits when every bit above the result's sign agrees
    assign re_top = sum_re[MAG_W+1:MAG_W-1];
    assign im_top = sum_im[MAG_W:MAG_W-1];

    always_comb begin
        if ((&re_top) || !(|re_top)) begin
            re_new = sum_re[MAG_W-1:0];
        end else begin
            re_new = sum_re[MAG_W+1] ? FIX_MIN : FIX_MAX;
        end
        if ((&im_top) || !(|im_top)) begin
            im_new = sum_im[MAG_W-1:0];
        end else begin
            im_new = sum_im[MAG_W] ? FIX_MIN : FIX_MAX;
        end
    end

    // Exact |z|^2 of the values that were squared
    assign mag_sq = {1'b0, p} + {1'b0, q};
    assign beyond = mag_sq > ESC_LIMIT;

endmodule

`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Iterates z = z*z + c from z = c for one point and reports how much of the
// iteration budget was left when |z|^2 first exceeded four.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Payload
//  --------  ---  -------------------  --------------------------------------
//  s_        in   s_tvalid / s_tready  s_tdata = c_re, c_im (Q4.28 each)
//  m_        out  m_tvalid / m_tready  m_tdata = remaining, m_tuser = escaped
//  cfg_      in   cfg_wr_en            cfg_wr_data = max_iter (no read-back)
//
//  Flow: one point at a time. Each iteration forms the magnitudes, runs them
//  through the squaring chain of NC = ceil((FRAC_BITS+6)/16) digit cells
//  and then updates z. A point runs at most max_iter passes (one for a zero
//  budget).
//  Reset: synchronous, active low; the budget returns to 30. No clearing pass.
//  Stalls: a finished result waits in the output register while the next
//  point is accepted; the block holds a second finished result until the
//  first is taken.
//
`default_nettype none

`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time #(
    parameter int FRAC_BITS = 28,
    parameter int ITER_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // config: budget register
    input  wire logic                       cfg_wr_en,
    input  wire logic [mbe_pkg::CFG_W-1:0]  cfg_wr_data,
    // input point
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [2*mbe_pkg::IN_W-1:0] s_tdata,   // [31:0] c_re, [63:32] c_im
    // result
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [mbe_pkg::REM_W-1:0]       m_tdata,   // [15:0] remaining
    output logic                            m_tuser    // [0] escaped
);
    import mbe_pkg::*;

    localparam int MAG_W = FRAC_BITS + INT_BITS;
    localparam int ACC_W = 2 * MAG_W;
    localparam int NC    = (MAG_W + DIGIT_W - 1) / DIGIT_W;
    // Input scaling to the internal fraction width
    localparam int UP    = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int DN    = (FRAC_BITS < IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;
    localparam int EXT_W = IN_W + UP;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAG,
        ST_MUL,
        ST_DONE
    } state_t;

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0] max_iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET;
        end else if (cfg_wr_en) begin
            max_iter_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------ input conversion
    logic signed [EXT_W-1:0] re_ext, im_ext, re_scl, im_scl;
    logic signed [MAG_W-1:0] c_re_in, c_im_in;

    // Scale up exactly, or scale down rounding toward minus infinity
    assign re_ext  = EXT_W'($signed(s_tdata[IN_W-1:0])) <<< UP;
    assign im_ext  = EXT_W'($signed(s_tdata[2*IN_W-1:IN_W])) <<< UP;
    assign re_scl  = re_ext >>> DN;
    assign im_scl  = im_ext >>> DN;
    assign c_re_in = MAG_W'(re_scl);
    assign c_im_in = MAG_W'(im_scl);

    // ------------------------------------------------------------- registers
    state_t                  state_reg, state_next;
    logic                    start_reg, start_next;
    logic                    first_reg, first_next;
    logic [ITER_BITS-1:0]    cnt_reg, cnt_next;
    logic signed [MAG_W-1:0] c_re_reg, c_re_next, c_im_reg, c_im_next;
    logic signed [MAG_W-1:0] z_re_reg, z_re_next, z_im_reg, z_im_next;
    logic [MAG_W-1:0]        ax_reg, ax_next, ay_reg, ay_next;
    logic                    r_neg_reg, r_neg_next;
    logic [REM_W-1:0]        res_rem_reg, res_rem_next;
    logic                    res_esc_reg, res_esc_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [REM_W-1:0]        m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    // ------------------------------------------------------- squaring chain
    logic [NC:0]      chain_v;
    logic [ACC_W-1:0] p_chain [NC+1];
    logic [ACC_W-1:0] q_chain [NC+1];
    logic [ACC_W-1:0] r_chain [NC+1];

    // The chain starts from empty sums; one token runs through per iteration
    assign chain_v[0] = start_reg;
    assign p_chain[0] = '0;
    assign q_chain[0] = '0;
    assign r_chain[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        mbe_cell #(
            .MAG_W (MAG_W),
            .IDX   (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .v_in    (chain_v[k]),
            .ax      (ax_reg),
            .ay      (ay_reg),
            .p_in    (p_chain[k]),
            .q_in    (q_chain[k]),
            .r_in    (r_chain[k]),
            .v_out   (chain_v[k+1]),
            .p_out   (p_chain[k+1]),
            .q_out   (q_chain[k+1]),
            .r_out   (r_chain[k+1])
        );
    end

    // ------------------------------------------------------------ update
    logic signed [MAG_W-1:0] re_new, im_new;
    logic                    beyond;

    mbe_step #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .p      (p_chain[NC]),
        .q      (q_chain[NC]),
        .r      (r_chain[NC]),
        .r_neg  (r_neg_reg),
        .c_re   (c_re_reg),
        .c_im   (c_im_reg),
        .re_new (re_new),
        .im_new (im_new),
        .beyond (beyond)
    );

    // -------------------------------------------------------------- control
    logic [ITER_BITS-1:0] budget;
    logic [ITER_BITS-1:0] cnt_dec;

    // A zero budget behaves as a budget of one
    always_comb begin
        budget = ITER_BITS'(max_iter_reg);
        if (budget == '0) begin
            budget = ITER_BITS'(1);
        end
    end

    assign cnt_dec = cnt_reg - ITER_BITS'(1);

    always_comb begin
        state_next    = state_reg;
        start_next    = 1'b0;
        first_next    = first_reg;
        cnt_next      = cnt_reg;
        c_re_next     = c_re_reg;
        c_im_next     = c_im_reg;
        z_re_next     = z_re_reg;
        z_im_next     = z_im_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        r_neg_next    = r_neg_reg;
        res_rem_next  = res_rem_reg;
        res_esc_next  = res_esc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                // Take a new point; z starts at c
                if (s_tvalid) begin
                    c_re_next  = c_re_in;
                    c_im_next  = c_im_in;
                    z_re_next  = c_re_in;
                    z_im_next  = c_im_in;
                    cnt_next   = budget;
                    first_next = 1'b1;
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                // Split z into magnitudes and the sign of re*im, then launch
                ax_next    = z_re_reg[MAG_W-1] ? $unsigned(-z_re_reg) : $unsigned(z_re_reg);
                ay_next    = z_im_reg[MAG_W-1] ? $unsigned(-z_im_reg) : $unsigned(z_im_reg);
                r_neg_next = z_re_reg[MAG_W-1] ^ z_im_reg[MAG_W-1];
                start_next = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (chain_v[NC]) begin
                    if (!first_reg && beyond) begin
                        // The previous step left the radius: report the count
                        res_rem_next = REM_W'(cnt_reg);
                        res_esc_next = 1'b1;
                        state_next   = ST_DONE;
                    end else if (cnt_dec == '0) begin
                        // Budget spent without escape
                        res_rem_next = '0;
                        res_esc_next = 1'b0;
                        state_next   = ST_DONE;
                    end else begin
                        z_re_next  = re_new;
                        z_im_next  = im_new;
                        cnt_next   = cnt_dec;
                        first_next = 1'b0;
                        state_next = ST_MAG;
                    end
                end
            end
            ST_DONE: begin
                // Hand the result over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_rem_reg;
                    m_tuser_next  = res_esc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        first_reg   <= first_next;
        cnt_reg     <= cnt_next;
        c_re_reg    <= c_re_next;
        c_im_reg    <= c_im_next;
        z_re_reg    <= z_re_next;
        z_im_reg    <= z_im_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        r_neg_reg   <= r_neg_next;
        res_rem_reg <= res_rem_next;
        res_esc_reg <= res_esc_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------ assertions
    `MBE_ASSERT_SAME(a_chain_one_token, aclk, aresetn, 1'b1, $onehot0(chain_v), "more than one token in the squaring chain")
    `MBE_ASSERT_SAME(a_chain_in_mul, aclk, aresetn, chain_v[NC], state_reg == ST_MUL, "chain finished outside the multiply phase")
    `MBE_ASSERT_SAME(a_budget_live, aclk, aresetn, (state_reg == ST_MAG) || (state_reg == ST_MUL), cnt_reg != '0, "iterating with an empty budget")
    `MBE_ASSERT_SAME(a_result_consistent, aclk, aresetn, m_tvalid, m_tuser == (m_tdata != '0), "escape flag disagrees with remaining count")
    `MBE_ASSERT_NEXT(a_continue_to_mag, aclk, aresetn, (state_reg == ST_MUL) && chain_v[NC] && (first_reg || !beyond) && (cnt_dec != '0), state_reg == ST_MAG, "iteration did not continue")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escape-time unit testbench
// Streams complex points into the escape-time unit under several iteration
// budgets, predicts each point's remaining count and escape flag in fixed
// point, and compares every result word with the oldest prediction while
// both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    // Arithmetic setup of the unit under test
    localparam int FRAC   = 28;
    localparam int ITER_W = 16;
    localparam int IW     = FRAC + mbe_pkg::INT_BITS;   // internal word, Q6.FRAC

    // Run control
    localparam int LIMIT       = 4_000_000;   // cycle cap for the whole run
    localparam int HOLD_CYCLES = 400;         // long receiver hold-off
    localparam int SETTLE      = 4;           // quiet cycles before a budget write
    localparam int TAIL        = 40;          // watch for stray words at the end

    typedef logic signed [IW-1:0] fix_t;
    typedef logic signed [71:0]   wide_t;     // holds any exact product or sum

    localparam wide_t FIX_HI    = (wide_t'(1) <<< (IW - 1)) - 1;
    localparam wide_t FIX_LO    = -(wide_t'(1) <<< (IW - 1));
    localparam wide_t ESC_LEVEL = wide_t'(mbe_pkg::ESC_BOUND_SQ) <<< (2 * FRAC);

    // One result word: remaining budget and escape flag
    typedef struct packed {
        logic [mbe_pkg::REM_W-1:0] remaining;
        logic                      escaped;
    } result_t;

    // One directed row: optional budget write, the point, optional typed answer
    typedef struct packed {
        logic                      wr;
        logic [mbe_pkg::CFG_W-1:0] budget;
        logic [31:0]               c_re;
        logic [31:0]               c_im;
        logic                      typed;
        logic [mbe_pkg::REM_W-1:0] rem;
        logic                      esc;
    } point_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [mbe_pkg::CFG_W-1:0]    cfg_wr_data = '0;
    logic                         s_tvalid    = 1'b0;
    logic                         s_tready;
    logic [2*mbe_pkg::IN_W-1:0]   s_tdata     = '0;   // [31:0] c_re, [63:32] c_im
    logic                         m_tvalid;
    logic                         m_tready    = 1'b0;
    logic [mbe_pkg::REM_W-1:0]    m_tdata;            // [15:0] remaining
    logic                         m_tuser;            // [0] escaped

    always #1 aclk = ~aclk;

    mandelbrot_escape_time #(
        .FRAC_BITS (FRAC),
        .ITER_BITS (ITER_W)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    result_t                   due_results[$];   // predictions, oldest first
    logic [mbe_pkg::CFG_W-1:0] budget = mbe_pkg::MAX_ITER_RESET;  // our copy of max_iter
    int                        faults = 0;
    int                        holds_asked = 0;  // bump to request a receiver hold-off
    bit                        no_idle = 1'b0;   // both sides run flat out while set
    int                        cycle_count = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Saturate an exact value to the internal Q6.FRAC range.
    function automatic fix_t clip(input wide_t v);
        if (v > FIX_HI) return fix_t'(FIX_HI);
        if (v < FIX_LO) return fix_t'(FIX_LO);
        return fix_t'(v);
    endfunction

    // Iterate z = z*z + c from z = c; count the budget down before each step
    // and stop once the exact |z|^2 is strictly above the escape level.
    function automatic result_t escape_count(input logic [31:0]               c_re,
                                             input logic [31:0]               c_im,
                                             input logic [mbe_pkg::CFG_W-1:0] iter_budget);
        fix_t              cre, cim, re, im, p, q, r;
        wide_t             wre, wim;
        logic [ITER_W-1:0] left;
        result_t           res;
        // Input and internal fractions match, so widening is a plain sign extension
        cre  = {{(IW-32){c_re[31]}}, c_re};
        cim  = {{(IW-32){c_im[31]}}, c_im};
        re   = cre;
        im   = cim;
        left = iter_budget;
        if (left == 0) left = ITER_W'(1);   // an empty budget acts as one
        left = left - ITER_W'(1);
        while (left != 0) begin
            wre = re;
            wim = im;
            // Arithmetic shift of the exact product floors toward minus infinity
            p  = clip((wre * wre) >>> FRAC);
            q  = clip((wim * wim) >>> FRAC);
            r  = clip((wre * wim) >>> (FRAC - 1));
            re = clip(wide_t'(p) - wide_t'(q) + wide_t'(cre));
            im = clip(wide_t'(r) + wide_t'(cim));
            wre = re;
            wim = im;
            if (wre * wre + wim * wim > ESC_LEVEL) break;
            left = left - ITER_W'(1);
        end
        res.remaining = left;
        res.escaped   = (left != 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Present one point and hold it until the block takes the word. A random
    // gap may come first; valid stays high across back-to-back words.
    task automatic offer_point(input logic [31:0] re, input logic [31:0] im);
        if (!no_idle && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
    endtask

    // Write max_iter only with the block idle.
    task automatic set_budget(input logic [mbe_pkg::CFG_W-1:0] value);
        drain();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        budget       = value;
    endtask

    // Mostly points around the set, some raw 32-bit noise, some range edges.
    task automatic pick_point(output logic [31:0] re, output logic [31:0] im);
        case ($urandom_range(0, 9))
            0, 1: begin
                re = $urandom;
                im = $urandom;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0:       re = 32'h8000_0000;
                    1:       re = 32'h7FFF_FFFF;
                    2:       re = 32'hFFFF_FFFF;
                    default: re = 32'hE000_0000;
                endcase
                im = ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : $urandom;
            end
            default: begin
                // window of roughly [-2.5, 0.5] x [-1.5, 1.5]
                re = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
                im = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
            end
        endcase
    endtask

    // Random points under one budget. Halfway through, optionally pause the
    // sender until the block drains, or ask the receiver for a long hold-off.
    task automatic random_phase(input logic [mbe_pkg::CFG_W-1:0] value, input int count,
                                input bit pause_mid, input bit hold_mid, input bit calm);
        logic [31:0] re, im;
        set_budget(value);
        no_idle = calm;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) begin
                if (pause_mid) drain();
                if (hold_mid) holds_asked++;
            end
            pick_point(re, im);
            offer_point(re, im);
            due_results.push_back(escape_count(re, im, budget));
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed points. Typed answers only where they are plain: the budget
    // after reset is 30, a first-step escape leaves 29, no steps leave 0.
    // ------------------------------------------------------------------------
    //                 wr    budget    c_re           c_im        typed rem     esc
    point_row_t plan [0:22] = '{
        // reset budget of 30
        '{1'b0, 16'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b0}, // origin
        '{1'b0, 16'd0,     32'h2000_0000, 32'h0000_0000, 1'b1, 16'd29,    1'b1}, // +2 escapes
        '{1'b0, 16'd0,     32'hE000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b0}, // |z|^2 == 4
        '{1'b0, 16'd0,     32'h0000_0000, 32'h1000_0000, 1'b1, 16'd0,     1'b0}, // i is periodic
        '{1'b0, 16'd0,     32'h8000_0000, 32'h8000_0000, 1'b1, 16'd29,    1'b1}, // both min
        '{1'b0, 16'd0,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd29,    1'b1}, // both max
        '{1'b0, 16'd0,     32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd29,    1'b1}, // max, min
        '{1'b0, 16'd0,     32'h8000_0000, 32'h0000_0000, 1'b1, 16'd29,    1'b1}, // -8 saturates
        '{1'b0, 16'd0,     32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 16'd0,     1'b0}, // floor rounding
        '{1'b0, 16'd0,     32'hF400_0000, 32'h0199_999A, 1'b0, 16'd0,     1'b0}, // -0.75+0.1i
        '{1'b0, 16'd0,     32'h0400_0000, 32'h0000_0000, 1'b0, 16'd0,     1'b0}, // cusp 0.25
        '{1'b0, 16'd0,     32'h04CC_CCCD, 32'h0800_0000, 1'b0, 16'd0,     1'b0}, // 0.3+0.5i
        '{1'b0, 16'd0,     32'hE800_0000, 32'h0000_0000, 1'b0, 16'd0,     1'b0}, // -1.5
        '{1'b0, 16'd0,     32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'd0,     1'b0}, // bit toggle
        // budget of one: no step at all
        '{1'b1, 16'd1,     32'h2000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b0},
        '{1'b0, 16'd0,     32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'd0,     1'b0},
        // empty budget behaves as one
        '{1'b1, 16'd0,     32'h2000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b0},
        // budget of two: exactly one step
        '{1'b1, 16'd2,     32'h2000_0000, 32'h0000_0000, 1'b1, 16'd1,     1'b1},
        '{1'b0, 16'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b0},
        '{1'b0, 16'd0,     32'h0800_0000, 32'h0800_0000, 1'b0, 16'd0,     1'b0},
        // full budget; the origin runs every pass
        '{1'b1, 16'hFFFF,  32'h2000_0000, 32'h0000_0000, 1'b1, 16'd65534, 1'b1},
        '{1'b0, 16'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b0},
        '{1'b0, 16'd0,     32'h0428_F5C3, 32'h0000_0000, 1'b0, 16'd0,     1'b0}  // slow 0.26
    };

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, then random phases over many budgets
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(plan); i++) begin
            if (plan[i].wr) set_budget(plan[i].budget);
            offer_point(plan[i].c_re, plan[i].c_im);
            if (plan[i].typed)
                due_results.push_back(result_t'{plan[i].rem, plan[i].esc});
            else
                due_results.push_back(escape_count(plan[i].c_re, plan[i].c_im, budget));
        end

        // Keep budgets small so points that never escape stay cheap
        //           budget  items pause  hold   calm
        random_phase(16'd30,  300, 1'b1, 1'b0, 1'b0);
        random_phase(16'd2,   200, 1'b0, 1'b1, 1'b0);   // fill the block, stall input
        random_phase(16'd1,    80, 1'b0, 1'b0, 1'b0);
        random_phase(16'd0,    60, 1'b0, 1'b0, 1'b0);
        random_phase(16'd64,  300, 1'b0, 1'b0, 1'b1);   // long stretch with no idling
        random_phase(16'd3,   160, 1'b0, 1'b0, 1'b0);
        random_phase(16'd200, 150, 1'b0, 1'b0, 1'b0);
        random_phase(16'd7,   200, 1'b0, 1'b0, 1'b0);
        random_phase(16'd5,   250, 1'b1, 1'b1, 1'b0);

        // Wait out every prediction, then watch a while for stray words
        drain();
        repeat (TAIL) @(posedge aclk);
        if (faults == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted word, then pick next cycle's ready
    // ------------------------------------------------------------------------
    initial begin : result_side
        int      hold_left;
        int      holds_seen;
        result_t want;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge aclk);
            // Values seen here are the ones the block saw at this edge
            if (aresetn && m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result word with nothing expected: remaining=%0d escaped=%0b",
                           m_tdata, m_tuser);
                    faults++;
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata !== want.remaining) begin
                        $error("remaining: expected %0d, got %0d", want.remaining, m_tdata);
                        faults++;
                    end
                    if (m_tuser !== want.escaped) begin
                        $error("escaped: expected %0b, got %0b", want.escaped, m_tuser);
                        faults++;
                    end
                end
            end
            // Start a requested hold-off; count it down here, not in the sender
            if (hold_left == 0 && holds_seen != holds_asked) begin
                holds_seen = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a hung handshake or a lost word ends the run here
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule
